>>> sv/pffe_pkg.sv
// Shared types, constants and codes of the prime factor function engine
package pffe_pkg;

	localparam int unsigned SIEVE_SIZE_DEF  = 65536;
	localparam int unsigned TABLE_DEPTH_DEF = 8192;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned ANSWER_W = 36;
	localparam int unsigned LIMIT_W  = 16;
	localparam int unsigned PRIME_W  = 16;
	localparam int unsigned MODE_W   = 3;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIEVE_LIMIT   = 1'd1;

	localparam logic [MODE_W-1:0] MODE_COUNT     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DISTINCT  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FSUM      = 3'd2;
	localparam logic [MODE_W-1:0] MODE_NDIV      = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SDIV      = 3'd4;
	localparam logic [MODE_W-1:0] MODE_TOTIENT   = 3'd5;

	localparam logic CMD_BUILD = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_B_CLR,
		ST_B_RD,
		ST_B_CHK,
		ST_B_MARK,
		ST_Q_RD,
		ST_Q_P,
		ST_Q_DIV,
		ST_Q_DEND,
		ST_Q_ACC,
		ST_Q_TAIL,
		ST_Q_TAIL2,
		ST_DONE
	} state_t;

endpackage

>>> sv/pffe_req_if.sv
// Request channel: command word with the value to factor
interface pffe_req_if;
	import pffe_pkg::*;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [VALUE_W-1:0] query_value;
	modport source (output valid, output cmd, output query_value, input ready);
	modport sink (input valid, input cmd, input query_value, output ready);
endinterface

>>> sv/pffe_rsp_if.sv
// Response channel: function result word with its error flag
interface pffe_rsp_if;
	import pffe_pkg::*;
	logic                valid;
	logic                ready;
	logic [ANSWER_W-1:0] answer;
	logic                error_flag;
	modport source (output valid, output answer, output error_flag, input ready);
	modport sink (input valid, input answer, input error_flag, output ready);
endinterface

>>> sv/prime_factor_function_engine_top.sv
// Prime factor function engine: sieve build and trial-division query sequencer
//
// A build word (cmd 0) sieves 2..min(sieve_limit, SIEVE_SIZE-1) in a bitmap RAM and stores
// the primes in a table RAM; it first sets the bitmap over 2..limit, one entry a cycle, then
// reads and checks each candidate and, for a prime whose square is within the limit, strikes
// its multiples in the bitmap; the answer is the number of primes stored. A query word (cmd 1)
// divides by the stored primes in turn with a one-bit-per-cycle divider: each prime tried
// takes a table read, a fetch, 32 divide steps and a remainder check, and each factor found
// adds an accumulate step, 32 more divide steps and another remainder check. One word is in
// flight at a time; a new word is taken while the previous result still waits on the
// response channel.
module prime_factor_function_engine_top #(
	parameter int unsigned SIEVE_SIZE        = pffe_pkg::SIEVE_SIZE_DEF,
	parameter int unsigned PRIME_TABLE_DEPTH = pffe_pkg::TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pffe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pffe_pkg::CFG_W-1:0]     cfg_data,
	pffe_req_if.sink                       req,
	pffe_rsp_if.source                     rsp
);
	import pffe_pkg::*;

	localparam int unsigned SW = $clog2(SIEVE_SIZE);
	localparam int unsigned PW = $clog2(PRIME_TABLE_DEPTH);
	localparam int unsigned CW = $clog2(PRIME_TABLE_DEPTH + 1);
	localparam logic [31:0] SIEVE_MAX  = 32'(SIEVE_SIZE - 1);
	localparam logic [CW-1:0] TABLE_FULL = CW'(PRIME_TABLE_DEPTH);

	state_t state_q, state_d;

	logic [MODE_W-1:0]  mode_q;
	logic [LIMIT_W-1:0] limit_q;

	// build registers
	logic [LIMIT_W-1:0] lim_q;
	logic [LIMIT_W-1:0] i_q;
	logic [31:0]        j_q;
	logic [CW-1:0]      count_q;
	logic [PRIME_W-1:0] last_q;

	// query registers
	logic [CW-1:0]       idx_q;
	logic [VALUE_W-1:0]  v_q;
	logic [PRIME_W-1:0]  p_q;
	logic [15:0]         rem_q;
	logic [VALUE_W-1:0]  dq_q;
	logic [4:0]          step_q;
	logic                first_q;
	logic [5:0]          cnt_q;
	logic [3:0]          dist_q;
	logic [ANSWER_W-1:0] fsum_q;
	logic [15:0]         ndiv_q;
	logic [15:0]         nd_base_q;
	logic [ANSWER_W-1:0] sd_q;
	logic [ANSWER_W-1:0] sd_cur_q;
	logic [ANSWER_W-1:0] sd_sum_q;
	logic [VALUE_W-1:0]  phi_q;
	logic                build_q;
	logic                err_q;

	// response register
	logic                rsp_valid_q;
	logic [ANSWER_W-1:0] rsp_answer_q;
	logic                rsp_err_q;

	// RAM ports
	logic          bm_we;
	logic [SW-1:0] bm_waddr;
	logic          bm_wdata;
	logic [SW-1:0] bm_raddr;
	logic          bm_rdata;
	logic          pt_we;
	logic [PW-1:0] pt_waddr;
	logic [PW-1:0] pt_raddr;
	logic [PRIME_W-1:0] pt_rdata;

	// combinational datapath
	logic               accept;
	logic [LIMIT_W-1:0] lim_new;
	logic [31:0]        i_sq;
	logic [31:0]        p_sq;
	logic [16:0]        nxt;
	logic [33:0]        nxt_sq;
	logic               exhausted;
	logic               too_big;
	logic [16:0]        rem_sh;
	logic               div_ge;
	logic [16:0]        rem_new;
	logic               rsp_free;
	logic [51:0]        sd_mul_p;
	logic [47:0]        phi_mul_p;
	logic [63:0]        phi_mul_v;
	logic [51:0]        sd_mul_lo;
	logic [51:0]        sd_mul_hi;
	logic [PRIME_W-1:0] phi_fac;
	logic [VALUE_W-1:0] v_m1;
	logic [ANSWER_W-1:0] q_answer;

	pffe_ram #(.WIDTH(1), .DEPTH(SIEVE_SIZE)) u_bitmap (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.raddr (bm_raddr),
		.rdata (bm_rdata)
	);

	pffe_ram #(.WIDTH(PRIME_W), .DEPTH(PRIME_TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (i_q),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	assign accept    = req.valid && req.ready;
	assign lim_new   = (32'(limit_q) > SIEVE_MAX) ? SIEVE_MAX[LIMIT_W-1:0] : limit_q;
	assign i_sq      = 32'(i_q) * 32'(i_q);
	assign p_sq      = 32'(pt_rdata) * 32'(pt_rdata);
	assign nxt       = 17'(last_q) + 17'd1;
	assign nxt_sq    = 34'(nxt) * 34'(nxt);
	assign exhausted = nxt_sq <= 34'(v_q);
	assign too_big   = (pt_rdata < 16'd2) || (p_sq > v_q);
	assign rem_sh    = {rem_q, dq_q[VALUE_W-1]};
	assign div_ge    = rem_sh >= {1'b0, p_q};
	assign rem_new   = div_ge ? (rem_sh - {1'b0, p_q}) : rem_sh;
	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign phi_fac   = first_q ? (p_q - 16'd1) : p_q;
	assign v_m1      = v_q - 32'd1;
	assign sd_mul_p  = 52'(sd_cur_q) * 52'(p_q);
	assign phi_mul_p = 48'(phi_q) * 48'(phi_fac);
	assign phi_mul_v = 64'(phi_q) * 64'(v_m1);
	assign sd_mul_lo = 52'(sd_q) * 52'(v_q[15:0]);
	assign sd_mul_hi = 52'(sd_q) * 52'(v_q[31:16]);

	always_comb begin
		unique case (mode_q)
			MODE_COUNT:    q_answer = ANSWER_W'(cnt_q);
			MODE_DISTINCT: q_answer = ANSWER_W'(dist_q);
			MODE_FSUM:     q_answer = fsum_q;
			MODE_NDIV:     q_answer = ANSWER_W'(ndiv_q);
			MODE_SDIV:     q_answer = sd_q;
			MODE_TOTIENT:  q_answer = ANSWER_W'(phi_q);
			default:       q_answer = '0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.cmd == CMD_BUILD) begin
						state_d = (lim_new < 16'd2) ? ST_DONE : ST_B_CLR;
					end else if (req.query_value == '0 || count_q == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_Q_RD;
					end
				end
			end
			ST_B_CLR: begin
				if (i_q == lim_q) begin
					state_d = ST_B_RD;
				end
			end
			ST_B_RD:  state_d = ST_B_CHK;
			ST_B_CHK: begin
				if (bm_rdata && i_sq <= 32'(lim_q)) begin
					state_d = ST_B_MARK;
				end else begin
					state_d = (i_q == lim_q) ? ST_DONE : ST_B_RD;
				end
			end
			ST_B_MARK: begin
				if (j_q + 32'(i_q) > 32'(lim_q)) begin
					state_d = (i_q == lim_q) ? ST_DONE : ST_B_RD;
				end
			end
			ST_Q_RD: begin
				if (idx_q == count_q) begin
					priority if (exhausted) state_d = ST_DONE;
					else if (v_q != 32'd1) state_d = ST_Q_TAIL;
					else state_d = ST_DONE;
				end else begin
					state_d = ST_Q_P;
				end
			end
			ST_Q_P: begin
				if (too_big) begin
					state_d = (v_q != 32'd1) ? ST_Q_TAIL : ST_DONE;
				end else begin
					state_d = ST_Q_DIV;
				end
			end
			ST_Q_DIV: begin
				if (step_q == 5'd31) begin
					state_d = ST_Q_DEND;
				end
			end
			ST_Q_DEND:  state_d = (rem_q == '0) ? ST_Q_ACC : ST_Q_RD;
			ST_Q_ACC:   state_d = ST_Q_DIV;
			ST_Q_TAIL:  state_d = ST_Q_TAIL2;
			ST_Q_TAIL2: state_d = ST_DONE;
			ST_DONE: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM control and handshake outputs
	always_comb begin
		bm_we    = 1'b0;
		bm_wdata = 1'b1;
		bm_waddr = SW'(i_q);
		bm_raddr = SW'(i_q);
		pt_we    = 1'b0;
		pt_waddr = count_q[PW-1:0];
		pt_raddr = idx_q[PW-1:0];
		unique case (state_q)
			ST_B_CLR: bm_we = 1'b1;
			ST_B_CHK: pt_we = bm_rdata && (count_q != TABLE_FULL);
			ST_B_MARK: begin
				bm_we    = 1'b1;
				bm_wdata = 1'b0;
				bm_waddr = SW'(j_q);
			end
			default: ;
		endcase
	end

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.answer     = rsp_answer_q;
	assign rsp.error_flag = rsp_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_COUNT;
			limit_q     <= '1;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FUNCTION_MODE: mode_q  <= cfg_data[MODE_W-1:0];
					REG_SIEVE_LIMIT:   limit_q <= cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (accept && req.cmd == CMD_BUILD) begin
				count_q <= '0;
			end else if (pt_we) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				build_q <= (req.cmd == CMD_BUILD);
				err_q   <= (req.query_value == '0 || count_q == '0);
				lim_q   <= lim_new;
				i_q     <= 16'd2;
				v_q     <= req.query_value;
				idx_q   <= '0;
				cnt_q   <= '0;
				dist_q  <= '0;
				fsum_q  <= '0;
				ndiv_q  <= 16'd1;
				sd_q    <= ANSWER_W'(1);
				phi_q   <= 32'd1;
			end
			ST_B_CLR: begin
				// restart at two once the bitmap is set
				i_q <= (i_q == lim_q) ? 16'd2 : i_q + 16'd1;
			end
			ST_B_CHK: begin
				j_q <= i_sq;
				if (pt_we) begin
					last_q <= i_q;
				end
				if (!(bm_rdata && i_sq <= 32'(lim_q)) && i_q != lim_q) begin
					i_q <= i_q + 16'd1;
				end
			end
			ST_B_MARK: begin
				j_q <= j_q + 32'(i_q);
				if (j_q + 32'(i_q) > 32'(lim_q) && i_q != lim_q) begin
					i_q <= i_q + 16'd1;
				end
			end
			ST_Q_RD: begin
				if (idx_q == count_q) begin
					err_q <= exhausted;
				end
			end
			ST_Q_P: begin
				p_q       <= pt_rdata;
				rem_q     <= '0;
				dq_q      <= v_q;
				step_q    <= '0;
				first_q   <= 1'b1;
				nd_base_q <= ndiv_q;
				sd_cur_q  <= sd_q;
				sd_sum_q  <= sd_q;
			end
			ST_Q_DIV: begin
				rem_q  <= rem_new[15:0];
				dq_q   <= {dq_q[VALUE_W-2:0], div_ge};
				step_q <= step_q + 5'd1;
			end
			ST_Q_DEND: begin
				if (rem_q == '0) begin
					v_q      <= dq_q;
					cnt_q    <= cnt_q + 6'd1;
					fsum_q   <= fsum_q + ANSWER_W'(p_q);
					ndiv_q   <= ndiv_q + nd_base_q;
					sd_cur_q <= sd_mul_p[ANSWER_W-1:0];
					phi_q    <= phi_mul_p[VALUE_W-1:0];
					if (first_q) begin
						dist_q <= dist_q + 4'd1;
					end
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_Q_ACC: begin
				// fold the next prime power into the divisor sum, then divide again
				first_q  <= 1'b0;
				sd_sum_q <= sd_sum_q + sd_cur_q;
				sd_q     <= sd_sum_q + sd_cur_q;
				rem_q    <= '0;
				dq_q     <= v_q;
				step_q   <= '0;
			end
			ST_Q_TAIL: begin
				cnt_q    <= cnt_q + 6'd1;
				dist_q   <= dist_q + 4'd1;
				fsum_q   <= fsum_q + ANSWER_W'(v_q);
				ndiv_q   <= {ndiv_q[14:0], 1'b0};
				phi_q    <= phi_mul_v[VALUE_W-1:0];
				sd_sum_q <= sd_q + sd_mul_lo[ANSWER_W-1:0];
			end
			ST_Q_TAIL2: begin
				sd_q <= sd_sum_q + {sd_mul_hi[ANSWER_W-17:0], 16'd0};
			end
			ST_DONE: begin
				if (rsp_free) begin
					if (build_q) begin
						rsp_answer_q <= ANSWER_W'(count_q);
						rsp_err_q    <= 1'b0;
					end else begin
						rsp_answer_q <= err_q ? '0 : q_answer;
						rsp_err_q    <= err_q;
					end
				end
			end
			default: ;
		endcase
	end
endmodule

>>> sv/pffe_ram.sv
// Generic simple dual-port RAM with registered read
module pffe_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> tb/pffe_checker.sv
// Checker of the prime factor function engine: predicts each result word and compares it
`timescale 1ns / 100ps
module pffe_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pffe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pffe_pkg::CFG_W-1:0]     cfg_data,
	pffe_req_if                            req,
	pffe_rsp_if                            rsp,
	output int                             pending,
	output int                             errors,
	output int                             n_builds,
	output int                             n_queries
);
	import pffe_pkg::*;

	typedef struct packed {
		logic [ANSWER_W-1:0] answer;
		logic                error_flag;
	} result_t;

	result_t             exp_mem[16];
	int unsigned         wr_cnt;
	int unsigned         rd_cnt;
	logic [MODE_W-1:0]   mode;
	logic [LIMIT_W-1:0]  limit;
	bit                  composite[SIEVE_SIZE_DEF];
	logic [PRIME_W-1:0]  primes[TABLE_DEPTH_DEF];
	int unsigned         n_primes;

	function automatic longint unsigned sieve_build();
		int unsigned top;
		top = (limit > SIEVE_SIZE_DEF - 1) ? SIEVE_SIZE_DEF - 1 : limit;
		n_primes = 0;
		if (top < 2) return 0;
		for (int unsigned i = 0; i <= top; i++) composite[i] = 1'b0;
		for (int unsigned i = 2; i <= top; i++) begin
			if (composite[i]) continue;
			for (longint unsigned j = longint'(i) * i; j <= top; j += i) composite[j] = 1'b1;
			if (n_primes < TABLE_DEPTH_DEF) begin
				primes[n_primes] = i[PRIME_W-1:0];
				n_primes++;
			end
		end
		return n_primes;
	endfunction

	// return 1 on error
	function automatic bit factor_query(input longint unsigned v, output longint unsigned res);
		longint unsigned cnt, n_dist, fsum, ndiv, sdiv, phi, p, e, pw, term, nxt;
		int unsigned idx;
		cnt = 0; n_dist = 0; fsum = 0; ndiv = 1; sdiv = 1; phi = v; idx = 0;
		res = 0;
		if (v == 0 || n_primes == 0) return 1'b1;
		forever begin
			if (idx >= n_primes) begin
				nxt = longint'(primes[n_primes-1]) + 1;
				if (nxt * nxt <= v) return 1'b1;
				break;
			end
			p = primes[idx];
			if (p < 2 || p * p > v) break;
			e = 0; pw = 1; term = 1;
			while (v % p == 0) begin
				v = v / p;
				e++;
				pw *= p;
				term += pw;
			end
			if (e != 0) begin
				cnt += e;
				n_dist++;
				fsum += e * p;
				ndiv *= e + 1;
				sdiv *= term;
				phi -= phi / p;
			end
			idx++;
		end
		// leftover factor is one prime
		if (v != 1) begin
			cnt++;
			n_dist++;
			fsum += v;
			ndiv *= 2;
			sdiv *= v + 1;
			phi -= phi / v;
		end
		case (mode)
			MODE_COUNT:    res = cnt;
			MODE_DISTINCT: res = n_dist;
			MODE_FSUM:     res = fsum;
			MODE_NDIV:     res = ndiv;
			MODE_SDIV:     res = sdiv;
			MODE_TOTIENT:  res = phi;
			default:       res = 0;
		endcase
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("%0t: %s: got %0d, want %0d", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t          want;
		longint unsigned  res;
		if (!arst_n) begin
			mode      = MODE_COUNT;
			limit     = '1;
			n_primes  = 0;
			errors    = 0;
			n_builds  = 0;
			n_queries = 0;
			wr_cnt    = 0;
			rd_cnt    = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_FUNCTION_MODE) mode = cfg_data[MODE_W-1:0];
				else if (cfg_index == REG_SIEVE_LIMIT) limit = cfg_data[LIMIT_W-1:0];
			end
			if (req.valid && req.ready) begin
				if (req.cmd == CMD_BUILD) begin
					res             = sieve_build();
					want.answer     = res[ANSWER_W-1:0];
					want.error_flag = 1'b0;
					n_builds++;
				end else begin
					want.error_flag = factor_query(req.query_value, res);
					want.answer     = res[ANSWER_W-1:0];
					n_queries++;
				end
				exp_mem[wr_cnt[3:0]] = want;
				wr_cnt++;
			end
			if (rsp.valid && rsp.ready) begin
				if (wr_cnt == rd_cnt) begin
					$display("%0t: result word with nothing expected", $time);
					errors++;
				end else begin
					want = exp_mem[rd_cnt[3:0]];
					rd_cnt++;
					if (rsp.answer !== want.answer)
						report_mismatch("answer", rsp.answer, want.answer);
					if (rsp.error_flag !== want.error_flag)
						report_mismatch("error_flag", rsp.error_flag, want.error_flag);
				end
			end
			pending <= int'(wr_cnt - rd_cnt);
		end
	end

endmodule

>>> tb/tb_prime_factor_function_engine_top.sv
// Testbench top of the prime factor function engine: stimulus, idling and verdict
`timescale 1ns / 100ps
module tb_prime_factor_function_engine_top;
	import pffe_pkg::*;

	localparam int SMALL_PRIMES[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
		43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	bit                   calm;
	int                   pending, errors, n_builds, n_queries;

	pffe_req_if req_ch ();
	pffe_rsp_if rsp_ch ();

	prime_factor_function_engine_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req_ch), .rsp(rsp_ch)
	);

	pffe_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req_ch), .rsp(rsp_ch), .pending(pending),
		.errors(errors), .n_builds(n_builds), .n_queries(n_queries)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("timeout");
		$display("end of test: mismatches");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= calm || ($urandom_range(99) >= 16);
		end
	end

	task automatic send_word(input logic cmd, input logic [VALUE_W-1:0] value);
		if (!calm && $urandom_range(99) < 16) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.cmd         <= cmd;
		req_ch.query_value <= value;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] factorable_value();
		longint unsigned v, p;
		v = 1;
		repeat ($urandom_range(7, 1)) begin
			p = SMALL_PRIMES[$urandom_range(24)];
			if (v * p <= 64'hFFFF_FFFF) v *= p;
		end
		// sometimes add a large leftover factor
		if ($urandom_range(3) == 0) begin
			p = $urandom_range(65535, 2);
			if (v * p <= 64'hFFFF_FFFF) v *= p;
		end
		return v[VALUE_W-1:0];
	endfunction

	function automatic logic [VALUE_W-1:0] random_value();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 60) return factorable_value();
		if (pick < 80) return $urandom();
		if (pick < 92) return $urandom_range(1000);
		case ($urandom_range(2))
			0: return '0;
			1: return 1;
			default: return '1;
		endcase
	endfunction

	initial begin
		logic [MODE_W-1:0] md;
		req_ch.valid       <= 1'b0;
		req_ch.cmd         <= CMD_BUILD;
		req_ch.query_value <= '0;
		cfg_we             <= 1'b0;
		cfg_index          <= REG_FUNCTION_MODE;
		cfg_data           <= '0;
		calm               = 1'b0;
		arst_n             = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// query before any build, then an empty table
		send_word(CMD_QUERY, 12);
		write_reg(REG_SIEVE_LIMIT, 0);
		send_word(CMD_BUILD, '1);
		send_word(CMD_QUERY, 5);
		write_reg(REG_SIEVE_LIMIT, 2);
		send_word(CMD_BUILD, 0);
		send_word(CMD_QUERY, 8);
		send_word(CMD_QUERY, 9);
		send_word(CMD_QUERY, 1);
		// largest sieve limit, every function on the values 360 and 1
		write_reg(REG_SIEVE_LIMIT, 16'hFFFF);
		send_word(CMD_BUILD, 0);
		for (int m = 0; m < 8; m++) begin
			write_reg(REG_FUNCTION_MODE, m[CFG_W-1:0]);
			send_word(CMD_QUERY, 360);
			send_word(CMD_QUERY, 1);
		end
		write_reg(REG_FUNCTION_MODE, MODE_TOTIENT);
		send_word(CMD_QUERY, 0);
		send_word(CMD_QUERY, 32'hFFFF_FFFF);
		write_reg(REG_FUNCTION_MODE, MODE_SDIV);
		send_word(CMD_QUERY, 32'hFFFF_FFFB);
		// table runs out
		write_reg(REG_SIEVE_LIMIT, 100);
		send_word(CMD_BUILD, 0);
		send_word(CMD_QUERY, 10403);
		send_word(CMD_QUERY, 9409);

		// random phases; small tables keep trial division short
		for (int ph = 0; ph < 6; ph++) begin
			calm = (ph == 2);
			md = (ph == 0) ? MODE_COUNT : (ph == 1) ? 3'd7 : MODE_W'($urandom_range(7));
			write_reg(REG_FUNCTION_MODE, md);
			write_reg(REG_SIEVE_LIMIT,
				(ph == 0) ? 16'd2 : (ph == 1) ? 16'd300 : CFG_W'($urandom_range(300)));
			send_word(CMD_BUILD, $urandom());
			repeat (18) begin
				if ($urandom_range(19) == 0) send_word(CMD_BUILD, $urandom());
				else send_word(CMD_QUERY, random_value());
			end
		end
		calm = 1'b0;

		drain();
		repeat (50) @(posedge clk);
		$display("covered %0d builds and %0d queries over all modes and sieve limits",
			n_builds, n_queries);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
